[hdl/qsl_pkg.sv]
// Shared types for the quicksort engine: data width, default capacity,
// datapath operation codes and the controller/datapath command and status bundles.
// No dependencies.
package qsl_pkg;

    localparam int DATA_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 64;

    // One datapath operation per controller step
    typedef enum logic [3:0] {
        OP_LOAD,
        OP_START,
        OP_POP,
        OP_RANGE,
        OP_PIVOT,
        OP_SCAN,
        OP_TEST,
        OP_SWAP1,
        OP_SWAP2,
        OP_FIN_RD,
        OP_FIN1,
        OP_FIN2,
        OP_PUSH_L,
        OP_PUSH_R,
        OP_EMIT_RD,
        OP_EMIT_LD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   in_ready;
    } dp_cmd_t;

    typedef struct packed {
        logic in_fire_last;  // item marked last accepted this cycle
        logic count_ge2;     // at least two elements stored
        logic less;          // scanned element below pivot
        logic i_eq_bound;    // scan index equals partition boundary
        logic last_i;        // scan index is the last one before the pivot
        logic bound_eq_hi;   // boundary already at pivot position
        logic push_r_ok;     // right subrange has two or more elements
        logic stack_empty;   // no range on the stack
        logic slot_free;     // output register can take a new item
        logic emit_last;     // element being emitted is the final one
    } dp_status_t;

endpackage

[hdl/quicksort_lomuto_engine.sv]
// Top level of the quicksort engine: joins controller and datapath.
// Depends on qsl_pkg, qsl_ctrl, qsl_datapath and qsl_ram.
//
// Usage:
//   Send signed 32-bit values on the s_axis channel, one item per cycle;
//   s_axis_tlast marks the final value of a set. Up to MAX_ELEMENTS values
//   are kept; further values are dropped and the set's overflow flag is set.
//   After the last item the set is sorted in place with Lomuto quicksort and
//   streamed out on m_axis in ascending order, m_axis_tlast on the final one,
//   m_axis_tuser carrying the overflow flag on every result of the set.
// Sorting steps:
//   Each range is popped from the stack and its last element read as pivot;
//   each other element is read and compared, and one below the pivot is swapped
//   with the boundary element; the pivot goes to the boundary and subranges
//   of two or more are pushed. Every step runs through the single read port
//   of the element RAM; each result is read, then put in the output register.
// Reset and stalls:
//   Reset empties the set and the stack; no clearing pass is needed.
//   s_axis_tready is low from the last item until the final result has been
//   loaded into the output register. A stalled receiver holds the output
//   register and pauses emission; the final result may wait there while the
//   next set already loads.
module quicksort_lomuto_engine #(
    parameter int MAX_ELEMENTS = qsl_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [qsl_pkg::DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic                       s_axis_tlast,   // last_element
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [qsl_pkg::DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
    output logic                       m_axis_tlast,   // last_result
    output logic                       m_axis_tuser    // [0] overflow
);
    import qsl_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    qsl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    qsl_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_ovf   (m_axis_tuser)
    );

    assign s_axis_tready = cmd.in_ready;

endmodule

[hdl/qsl_ram.sv]
// Generic single-write, single-read RAM with registered read data and read enable.
// No dependencies.
module qsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/qsl_ctrl.sv]
// Controller of the quicksort engine: one-hot state machine that sequences
// load, partition, stack and emission steps. Depends on qsl_pkg.
module qsl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  qsl_pkg::dp_status_t status,
    output qsl_pkg::dp_cmd_t    cmd
);
    import qsl_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE    = 16'b0000_0000_0000_0001,
        S_START   = 16'b0000_0000_0000_0010,
        S_POP     = 16'b0000_0000_0000_0100,
        S_RANGE   = 16'b0000_0000_0000_1000,
        S_PIVOT   = 16'b0000_0000_0001_0000,
        S_SCAN    = 16'b0000_0000_0010_0000,
        S_TEST    = 16'b0000_0000_0100_0000,
        S_SWAP1   = 16'b0000_0000_1000_0000,
        S_SWAP2   = 16'b0000_0001_0000_0000,
        S_FIN_RD  = 16'b0000_0010_0000_0000,
        S_FIN1    = 16'b0000_0100_0000_0000,
        S_FIN2    = 16'b0000_1000_0000_0000,
        S_PUSH_L  = 16'b0001_0000_0000_0000,
        S_PUSH_R  = 16'b0010_0000_0000_0000,
        S_EMIT_RD = 16'b0100_0000_0000_0000,
        S_EMIT_LD = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (status.in_fire_last)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = status.count_ge2 ? S_POP : S_EMIT_RD;
            end
            S_POP:   state_next = S_RANGE;
            S_RANGE: state_next = S_PIVOT;
            S_PIVOT: state_next = S_SCAN;
            S_SCAN:  state_next = S_TEST;
            S_TEST:
            begin
                if (status.less && !status.i_eq_bound)
                begin
                    state_next = S_SWAP1;
                end
                else
                begin
                    state_next = status.last_i ? S_FIN_RD : S_SCAN;
                end
            end
            S_SWAP1: state_next = S_SWAP2;
            S_SWAP2:
            begin
                state_next = status.last_i ? S_FIN_RD : S_SCAN;
            end
            S_FIN_RD:
            begin
                state_next = status.bound_eq_hi ? S_PUSH_L : S_FIN1;
            end
            S_FIN1:   state_next = S_FIN2;
            S_FIN2:   state_next = S_PUSH_L;
            S_PUSH_L: state_next = S_PUSH_R;
            S_PUSH_R:
            begin
                if (status.stack_empty && !status.push_r_ok)
                begin
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_EMIT_RD: state_next = S_EMIT_LD;
            S_EMIT_LD:
            begin
                if (status.slot_free)
                begin
                    state_next = status.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Map state to datapath operation
    always_comb
    begin
        cmd.in_ready = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:    cmd.op = OP_LOAD;
            S_START:   cmd.op = OP_START;
            S_POP:     cmd.op = OP_POP;
            S_RANGE:   cmd.op = OP_RANGE;
            S_PIVOT:   cmd.op = OP_PIVOT;
            S_SCAN:    cmd.op = OP_SCAN;
            S_TEST:    cmd.op = OP_TEST;
            S_SWAP1:   cmd.op = OP_SWAP1;
            S_SWAP2:   cmd.op = OP_SWAP2;
            S_FIN_RD:  cmd.op = OP_FIN_RD;
            S_FIN1:    cmd.op = OP_FIN1;
            S_FIN2:    cmd.op = OP_FIN2;
            S_PUSH_L:  cmd.op = OP_PUSH_L;
            S_PUSH_R:  cmd.op = OP_PUSH_R;
            S_EMIT_RD: cmd.op = OP_EMIT_RD;
            S_EMIT_LD: cmd.op = OP_EMIT_LD;
            default:   cmd.op = OP_LOAD;
        endcase
    end

endmodule

[hdl/qsl_datapath.sv]
// Datapath of the quicksort engine: element store, range stack, scan indexes,
// pivot compare and output register. Depends on qsl_pkg and qsl_ram.
module qsl_datapath #(
    parameter int MAX_ELEMENTS = qsl_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  qsl_pkg::dp_cmd_t           cmd,
    output qsl_pkg::dp_status_t        status,
    input  logic                       in_valid,
    input  logic [qsl_pkg::DATA_W-1:0] in_data,
    input  logic                       in_last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [qsl_pkg::DATA_W-1:0] out_data,
    output logic                       out_last,
    output logic                       out_ovf
);
    import qsl_pkg::*;

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int STK_W = 2 * IDX_W;

    // Control and index registers
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     dropped_reg, dropped_next;
    logic [CNT_W-1:0]         sp_reg, sp_next;
    logic [IDX_W-1:0]         lo_reg, lo_next;
    logic [IDX_W-1:0]         hi_reg, hi_next;
    logic [IDX_W-1:0]         i_reg, i_next;
    logic [IDX_W-1:0]         bound_reg, bound_next;
    logic [IDX_W-1:0]         k_reg, k_next;
    logic signed [DATA_W-1:0] pivot_reg, pivot_next;
    logic [DATA_W-1:0]        hold_reg, hold_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]        out_data_reg, out_data_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_ovf_reg, out_ovf_next;

    // Memory ports
    logic              e_we, e_re;
    logic [IDX_W-1:0]  e_waddr, e_raddr;
    logic [DATA_W-1:0] e_wdata, e_rdata;
    logic              s_we, s_re;
    logic [IDX_W-1:0]  s_waddr, s_raddr;
    logic [STK_W-1:0]  s_wdata, s_rdata;

    // Derived values
    logic             in_fire;
    logic [CNT_W-1:0] count_m1;
    logic [CNT_W-1:0] sp_m1;
    logic [CNT_W-1:0] k_inc;
    logic [IDX_W:0]   i_inc;
    logic [IDX_W:0]   bound_inc;
    logic [IDX_W:0]   lo_inc;
    logic             less;
    logic             push_l_ok;
    logic             push_r_ok;
    logic             slot_free;
    logic             emit_last;

    qsl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_elem_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .re    (e_re),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    qsl_ram #(
        .WIDTH (STK_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // Compare and index arithmetic
    assign in_fire   = in_valid && cmd.in_ready;
    assign count_m1  = count_reg - 1'b1;
    assign sp_m1     = sp_reg - 1'b1;
    assign k_inc     = CNT_W'(k_reg) + 1'b1;
    assign i_inc     = {1'b0, i_reg} + 1'b1;
    assign bound_inc = {1'b0, bound_reg} + 1'b1;
    assign lo_inc    = {1'b0, lo_reg} + 1'b1;
    assign less      = $signed(e_rdata) < pivot_reg;
    assign push_l_ok = {1'b0, bound_reg} > lo_inc;
    assign push_r_ok = bound_inc < {1'b0, hi_reg};
    assign slot_free = !out_valid_reg || out_ready;
    assign emit_last = (k_inc == count_reg);

    // Status to controller
    always_comb
    begin
        status.in_fire_last = in_fire && in_last;
        status.count_ge2    = (count_reg >= CNT_W'(2));
        status.less         = less;
        status.i_eq_bound   = (i_reg == bound_reg);
        status.last_i       = (i_inc == {1'b0, hi_reg});
        status.bound_eq_hi  = (bound_reg == hi_reg);
        status.push_r_ok    = push_r_ok;
        status.stack_empty  = (sp_reg == '0);
        status.slot_free    = slot_free;
        status.emit_last    = emit_last;
    end

    // Operation decode
    always_comb
    begin
        e_we    = 1'b0;
        e_waddr = bound_reg;
        e_wdata = hold_reg;
        e_re    = 1'b0;
        e_raddr = i_reg;
        s_we    = 1'b0;
        s_waddr = sp_reg[IDX_W-1:0];
        s_wdata = {lo_reg, bound_reg - 1'b1};
        s_re    = 1'b0;
        s_raddr = sp_m1[IDX_W-1:0];

        count_next   = count_reg;
        dropped_next = dropped_reg;
        sp_next      = sp_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        i_next       = i_reg;
        bound_next   = bound_reg;
        k_next       = k_reg;
        pivot_next   = pivot_reg;
        hold_next    = hold_reg;

        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        case (cmd.op)
            OP_LOAD:
            begin
                // Store the item, or drop it when full
                if (in_fire)
                begin
                    if (count_reg < CNT_W'(MAX_ELEMENTS))
                    begin
                        e_we       = 1'b1;
                        e_waddr    = count_reg[IDX_W-1:0];
                        e_wdata    = in_data;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
            end
            OP_START:
            begin
                // Push the whole set as the first range when it holds two or more elements
                k_next = '0;
                if (count_reg >= CNT_W'(2))
                begin
                    s_we    = 1'b1;
                    s_waddr = '0;
                    s_wdata = {{IDX_W{1'b0}}, count_m1[IDX_W-1:0]};
                    sp_next = CNT_W'(1);
                end
            end
            OP_POP:
            begin
                s_re    = 1'b1;
                sp_next = sp_m1;
            end
            OP_RANGE:
            begin
                // Take bounds and fetch the pivot
                lo_next = s_rdata[STK_W-1:IDX_W];
                hi_next = s_rdata[IDX_W-1:0];
                e_re    = 1'b1;
                e_raddr = s_rdata[IDX_W-1:0];
            end
            OP_PIVOT:
            begin
                pivot_next = e_rdata;
                i_next     = lo_reg;
                bound_next = lo_reg;
            end
            OP_SCAN:
            begin
                e_re    = 1'b1;
                e_raddr = i_reg;
            end
            OP_TEST:
            begin
                hold_next = e_rdata;
                if (less && (i_reg != bound_reg))
                begin
                    e_re    = 1'b1;
                    e_raddr = bound_reg;
                end
                else if (less)
                begin
                    bound_next = bound_inc[IDX_W-1:0];
                    i_next     = i_inc[IDX_W-1:0];
                end
                else
                begin
                    i_next = i_inc[IDX_W-1:0];
                end
            end
            OP_SWAP1:
            begin
                // Move the smaller element forward
                e_we      = 1'b1;
                e_waddr   = bound_reg;
                e_wdata   = hold_reg;
                hold_next = e_rdata;
            end
            OP_SWAP2:
            begin
                e_we       = 1'b1;
                e_waddr    = i_reg;
                e_wdata    = hold_reg;
                bound_next = bound_inc[IDX_W-1:0];
                i_next     = i_inc[IDX_W-1:0];
            end
            OP_FIN_RD:
            begin
                e_re    = 1'b1;
                e_raddr = bound_reg;
            end
            OP_FIN1:
            begin
                // Place the pivot at the boundary
                e_we      = 1'b1;
                e_waddr   = bound_reg;
                e_wdata   = pivot_reg;
                hold_next = e_rdata;
            end
            OP_FIN2:
            begin
                e_we    = 1'b1;
                e_waddr = hi_reg;
                e_wdata = hold_reg;
            end
            OP_PUSH_L:
            begin
                if (push_l_ok)
                begin
                    s_we    = 1'b1;
                    s_wdata = {lo_reg, bound_reg - 1'b1};
                    sp_next = sp_reg + 1'b1;
                end
            end
            OP_PUSH_R:
            begin
                if (push_r_ok)
                begin
                    s_we    = 1'b1;
                    s_wdata = {bound_inc[IDX_W-1:0], hi_reg};
                    sp_next = sp_reg + 1'b1;
                end
            end
            OP_EMIT_RD:
            begin
                e_re    = 1'b1;
                e_raddr = k_reg;
            end
            OP_EMIT_LD:
            begin
                // Load the output register, then close the set on the last item
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = e_rdata;
                    out_last_next  = emit_last;
                    out_ovf_next   = dropped_reg;
                    if (emit_last)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        sp_next      = '0;
                    end
                    else
                    begin
                        k_next = k_inc[IDX_W-1:0];
                    end
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        i_reg        <= i_next;
        bound_reg    <= bound_next;
        k_reg        <= k_next;
        pivot_reg    <= pivot_next;
        hold_reg     <= hold_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = out_ovf_reg;

endmodule

[hdl/qsl_checker.sv]
// Port-level checks for the quicksort engine, bound to its top level.
// Depends on qsl_pkg and quicksort_lomuto_engine.
module qsl_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [qsl_pkg::DATA_W-1:0] s_axis_tdata,
    input logic                       s_axis_tlast,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [qsl_pkg::DATA_W-1:0] m_axis_tdata,
    input logic                       m_axis_tlast,
    input logic                       m_axis_tuser
);

    // Stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // Loading continues after a non-final item
    a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
        else $error("input closed in the middle of a set");

    // Final item closes the input for sorting
    a_sort_closes: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still open after the final item");

    // Input reopens only with the final result in the output register
    a_reopen_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_axis_tready) |-> m_axis_tvalid && m_axis_tlast)
        else $error("input reopened before the final result was loaded");

endmodule

bind quicksort_lomuto_engine qsl_checker u_qsl_checker (.*);

[bench/testbench.sv]
// Self-checking testbench for quicksort_lomuto_engine: streams sets of signed values
// in, predicts each sorted run with a local Lomuto quicksort and checks every result.
// Depends on qsl_pkg and the quicksort_lomuto_engine RTL.
`timescale 1ns / 100ps

module testbench;

    import qsl_pkg::*;

    localparam int CAPACITY       = MAX_ELEMENTS_DEF;
    localparam int TARGET_ITEMS   = 380;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLD_CYCLES    = 600;
    localparam int HOLD_AT_RESULT = 30;

    typedef enum int {
        FULL_RANGE,
        FEW_DISTINCT,
        EDGE_VALUES,
        RAMP_UP,
        RAMP_DOWN
    } value_style_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } load_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              overflow;
    } sorted_item_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              m_axis_tlast;
    logic              m_axis_tuser;

    load_item_t   pending_items[$];
    sorted_item_t expected_sorted[$];
    load_item_t   next_item;
    sorted_item_t want;

    // Predictor state: the set being loaded
    logic signed [DATA_W-1:0] set_store [CAPACITY];
    int                       set_count   = 0;
    logic                     set_dropped = 1'b0;

    int   error_count  = 0;
    int   results_seen = 0;
    int   idle_cycles  = 0;
    int   tx_gap       = 0;
    int   rx_gap       = 0;
    int   long_hold    = 0;
    logic tx_calm      = 1'b0;
    logic rx_calm      = 1'b0;

    quicksort_lomuto_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    // Mostly short stalls, a few long ones
    function automatic int stall_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 3);
        else if (pick < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic logic [DATA_W-1:0] value_for(value_style_t style, int idx);
        case (style)
            FEW_DISTINCT: return DATA_W'($signed($urandom_range(0, 15)) - 8);
            EDGE_VALUES:
                case ($urandom_range(0, 6))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    3:       return 32'hffff_ffff;
                    4:       return 32'h0000_0001;
                    5:       return 32'h8000_0001;
                    default: return 32'h7fff_fffe;
                endcase
            RAMP_UP:     return DATA_W'(idx * 1000 - 30000);
            RAMP_DOWN:   return DATA_W'(30000 - idx * 977);
            default:     return $urandom();
        endcase
    endfunction

    task automatic queue_value(logic [DATA_W-1:0] value, logic last);
        load_item_t item;
        item.value = value;
        item.last  = last;
        pending_items.push_back(item);
    endtask

    task automatic queue_set(int size, value_style_t style);
        for (int idx = 0; idx < size; idx++)
            queue_value(value_for(style, idx), idx == size - 1);
    endtask

    // Sort the loaded set with Lomuto partitioning and queue its results
    task automatic sort_set_and_queue();
        int                       lo_stack[$];
        int                       hi_stack[$];
        int                       lo;
        int                       hi;
        int                       bound;
        logic signed [DATA_W-1:0] pivot;
        logic signed [DATA_W-1:0] held;
        sorted_item_t             result;
        if (set_count >= 2)
        begin
            lo_stack.push_back(0);
            hi_stack.push_back(set_count - 1);
        end
        while (lo_stack.size() > 0)
        begin
            lo    = lo_stack.pop_back();
            hi    = hi_stack.pop_back();
            pivot = set_store[hi];
            bound = lo;
            for (int i = lo; i < hi; i++)
            begin
                if (set_store[i] < pivot)
                begin
                    held             = set_store[i];
                    set_store[i]     = set_store[bound];
                    set_store[bound] = held;
                    bound++;
                end
            end
            set_store[hi]    = set_store[bound];
            set_store[bound] = pivot;
            // push only ranges of two or more elements
            if (bound - 1 > lo)
            begin
                lo_stack.push_back(lo);
                hi_stack.push_back(bound - 1);
            end
            if (bound + 1 < hi)
            begin
                lo_stack.push_back(bound + 1);
                hi_stack.push_back(hi);
            end
        end
        for (int k = 0; k < set_count; k++)
        begin
            result.value    = set_store[k];
            result.last     = (k == set_count - 1);
            result.overflow = set_dropped;
            expected_sorted.push_back(result);
        end
        set_count   = 0;
        set_dropped = 1'b0;
    endtask

    // Store one accepted item; drop it when the store is full
    task automatic absorb_item(logic [DATA_W-1:0] value, logic last);
        if (set_count < CAPACITY)
        begin
            set_store[set_count] = value;
            set_count++;
        end
        else
            set_dropped = 1'b1;
        if (last)
            sort_set_and_queue();
    endtask

    // Sender: present queued items with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                absorb_item(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    next_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_item.value;
                    s_axis_tlast  <= next_item.last;
                    if ($urandom_range(0, 39) == 0)
                        tx_calm = !tx_calm;
                    tx_gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : stall_length();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: check each result and stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (results_seen == HOLD_AT_RESULT)
                    long_hold = HOLD_CYCLES;
                if (expected_sorted.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: sorted_value %0d last %0b overflow %0b",
                                 $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
                end
                else
                begin
                    want = expected_sorted.pop_front();
                    if (m_axis_tdata !== want.value || m_axis_tlast !== want.last ||
                        m_axis_tuser !== want.overflow)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: sorted_value exp %0d got %0d, last exp %0b got %0b, overflow exp %0b got %0b",
                                     $signed(want.value), $signed(m_axis_tdata),
                                     want.last, m_axis_tlast, want.overflow, m_axis_tuser);
                    end
                end
            end
            if (long_hold > 0)
            begin
                long_hold--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 49) == 0)
                    rx_calm = !rx_calm;
                if (!rx_calm && $urandom_range(0, 3) == 0)
                begin
                    rx_gap = stall_length() - 1;
                    m_axis_tready <= 1'b0;
                end
                else
                    m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        // Directed: single elements, extremes, duplicates, presorted and reverse-sorted runs
        queue_value(32'h7fff_ffff, 1'b1);
        queue_value(32'h8000_0000, 1'b1);
        queue_value(32'h7fff_ffff, 1'b0);
        queue_value(32'h8000_0000, 1'b1);
        queue_value(32'h0000_0000, 1'b0);
        queue_value(32'hffff_ffff, 1'b0);
        queue_value(32'h7fff_ffff, 1'b0);
        queue_value(32'h8000_0000, 1'b0);
        queue_value(32'h0000_0001, 1'b0);
        queue_value(32'h8000_0000, 1'b1);
        for (int n = 0; n < 4; n++)
            queue_value(32'd5, n == 3);
        queue_set(5, RAMP_UP);
        queue_set(5, RAMP_DOWN);

        // Random: mostly small sets, one full presorted set, one overflowing set
        queue_set(CAPACITY, RAMP_UP);
        while (pending_items.size() < TARGET_ITEMS)
        begin
            if (pending_items.size() > 200 && pending_items.size() < 220)
                queue_set(CAPACITY + 2, FULL_RANGE);
            else
                case ($urandom_range(0, 3))
                    0:       queue_set($urandom_range(1, 14), FEW_DISTINCT);
                    1:       queue_set($urandom_range(1, 14), EDGE_VALUES);
                    default: queue_set($urandom_range(1, 14), FULL_RANGE);
                endcase
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || s_axis_tvalid || expected_sorted.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && expected_sorted.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

[sim.f]
hdl/qsl_pkg.sv
hdl/qsl_ram.sv
hdl/qsl_ctrl.sv
hdl/qsl_datapath.sv
hdl/quicksort_lomuto_engine.sv
hdl/qsl_checker.sv
bench/testbench.sv
